@@ rtl/tbb_pkg.sv @@
// shared types and constants of the transformed box bounds unit
package tbb_pkg;

  // fixed widths of the coordinate and size fields
  localparam int COORD_W  = 32;
  localparam int SIZE_W   = COORD_W - 1;
  localparam int NUM_ROWS = 3;
  localparam int NUM_AXES = 3;
  localparam int ROW_W    = 2;

  // beat layout on both channels
  localparam int IN_TDATA_W   = 10 * COORD_W;
  localparam int IN_TUSER_W   = 1 + ROW_W;
  localparam int OUT_FIELDS_W = 6 * COORD_W + 3 * SIZE_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // item kinds carried in tuser bit 0
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_BOX  = 1'b1;

  typedef logic [COORD_W-1:0] tbb_coord_t;
  typedef tbb_coord_t [3:0] tbb_row_t;            // a, b, c, d from index 0 up
  typedef tbb_row_t [NUM_ROWS-1:0] tbb_mat_t;
  typedef tbb_coord_t [NUM_AXES-1:0] tbb_vec_t;   // x, y, z from index 0 up

  // per-stage load enables of the datapath
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } tbb_stage_en_t;

endpackage

@@ rtl/tbb_matrix.sv @@
// matrix row storage: three affine rows, identity after reset
module tbb_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic [1:0]         row,
  input  tbb_pkg::tbb_row_t  coefs,
  output tbb_pkg::tbb_mat_t  mat
);
  import tbb_pkg::*;

  localparam tbb_coord_t ONE = COORD_W'(1) << FRAC_BITS;

  logic row_ok;

  // the row code past the last row is ignored
  assign row_ok = row < ROW_W'(NUM_ROWS);

  // row write on a load beat
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < 4; c++) begin
          mat[r][c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (load && row_ok) begin
      mat[row] <= coefs;
    end
  end

endmodule

@@ rtl/tbb_pipe_ctl.sv @@
// valid bits and ready chain of the five-stage datapath
module tbb_pipe_ctl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_box,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output tbb_pkg::tbb_stage_en_t  en
);
  import tbb_pkg::*;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // a stage takes new data when empty or when its content moves on
  assign rdy5 = !v5 || out_ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign en       = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5};
  assign in_ready = rdy1;
  assign out_valid = v5;

  // only box beats occupy a slot; load beats finish at the input
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid && in_box;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

endmodule

@@ rtl/tbb_row_path.sv @@
// one output axis: products, per-axis min/max, row sum and saturation
module tbb_row_path #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  tbb_pkg::tbb_stage_en_t  en,
  input  tbb_pkg::tbb_row_t       coefs,
  input  tbb_pkg::tbb_vec_t       bmin,
  input  tbb_pkg::tbb_vec_t       bmax,
  output tbb_pkg::tbb_coord_t     lo,
  output tbb_pkg::tbb_coord_t     hi
);
  import tbb_pkg::*;

  localparam int PROD_W = 2 * COORD_W;
  localparam int TERM_W = PROD_W - FRAC_BITS;
  localparam int SUM_W  = TERM_W + 2;
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

  logic signed [PROD_W-1:0] prod_a [NUM_AXES];
  logic signed [PROD_W-1:0] prod_b [NUM_AXES];
  logic signed [TERM_W-1:0] term_a [NUM_AXES];
  logic signed [TERM_W-1:0] term_b [NUM_AXES];
  logic signed [TERM_W-1:0] t_lo [NUM_AXES];
  logic signed [TERM_W-1:0] t_hi [NUM_AXES];
  logic signed [COORD_W-1:0] d1, d2;
  logic signed [SUM_W-1:0] sum_lo, sum_hi;
  logic signed [SUM_W-1:0] sum_lo_next, sum_hi_next;

  // stage 1: products at both ends of each input axis, floor to fraction
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      prod_a[k] = $signed(coefs[k]) * $signed(bmin[k]);
      prod_b[k] = $signed(coefs[k]) * $signed(bmax[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        term_a[k] <= prod_a[k][PROD_W-1:FRAC_BITS];
        term_b[k] <= prod_b[k][PROD_W-1:FRAC_BITS];
      end
      d1 <= $signed(coefs[3]);
    end
  end

  // stage 2: the row sum separates per axis, so pick the smaller and larger term
  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        t_lo[k] <= (term_a[k] < term_b[k]) ? term_a[k] : term_b[k];
        t_hi[k] <= (term_a[k] < term_b[k]) ? term_b[k] : term_a[k];
      end
      d2 <= d1;
    end
  end

  // stage 3: exact row sums plus translation
  always_comb begin
    sum_lo_next = SUM_W'(t_lo[0]) + SUM_W'(t_lo[1]) + SUM_W'(t_lo[2]) + SUM_W'(d2);
    sum_hi_next = SUM_W'(t_hi[0]) + SUM_W'(t_hi[1]) + SUM_W'(t_hi[2]) + SUM_W'(d2);
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      sum_lo <= sum_lo_next;
      sum_hi <= sum_hi_next;
    end
  end

  // stage 4: saturate to the coordinate range
  always_ff @(posedge clk) begin
    if (en.s4) begin
      if (sum_lo > SAT_MAX)      lo <= SAT_MAX[COORD_W-1:0];
      else if (sum_lo < SAT_MIN) lo <= SAT_MIN[COORD_W-1:0];
      else                       lo <= sum_lo[COORD_W-1:0];
      if (sum_hi > SAT_MAX)      hi <= SAT_MAX[COORD_W-1:0];
      else if (sum_hi < SAT_MIN) hi <= SAT_MIN[COORD_W-1:0];
      else                       hi <= sum_hi[COORD_W-1:0];
    end
  end

endmodule

@@ rtl/transformed_box_bounds_unit.sv @@
// top level of the transformed box bounds unit
//
// channel   dir  beat contents
// s_axis    in   tuser: action, row; tdata: coef_a..coef_d, min_x..max_z
// m_axis    out  tdata: out_min_x..out_max_z, size_x..size_z
//
// five register stages: products, per-axis min/max, row sum, saturation,
// size and output register; m_axis_tvalid is the valid bit of the output register
// one beat per cycle is accepted unless a stall has filled every stage; a stage moves when empty or emptied
// a load beat writes its matrix row (row 3 is ignored) at the accept edge and makes no result
// rst (synchronous) empties the pipeline and restores the identity matrix
// a stall at m_axis_tready holds occupied stages back to the first empty one; stages before it still fill
module transformed_box_bounds_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // coef_a, coef_b, coef_c, coef_d, min_x, min_y, min_z, max_x, max_y, max_z
  input  logic [tbb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // action, row
  input  logic [tbb_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
  // size_x, size_y, size_z, zero pad
  output logic [tbb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import tbb_pkg::*;

  logic          action;
  logic [1:0]    row;
  logic          load;
  tbb_row_t      in_coefs;
  tbb_vec_t      bmin, bmax;
  tbb_mat_t      mat;
  tbb_stage_en_t en;
  tbb_coord_t    lo [NUM_AXES];
  tbb_coord_t    hi [NUM_AXES];
  tbb_coord_t    out_lo [NUM_AXES];
  tbb_coord_t    out_hi [NUM_AXES];
  logic [SIZE_W-1:0] size_q [NUM_AXES];
  logic [COORD_W:0]  diff [NUM_AXES];

  // beat fields
  assign action   = s_axis_tuser[0];
  assign row      = s_axis_tuser[ROW_W:1];
  assign in_coefs = s_axis_tdata[4*COORD_W-1:0];
  assign bmin     = s_axis_tdata[7*COORD_W-1:4*COORD_W];
  assign bmax     = s_axis_tdata[10*COORD_W-1:7*COORD_W];
  assign load     = s_axis_tvalid && s_axis_tready && (action == ACT_LOAD);

  tbb_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .row   (row),
    .coefs (in_coefs),
    .mat   (mat)
  );

  tbb_pipe_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_box    (action == ACT_BOX),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .en        (en)
  );

  // one datapath per output axis
  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    tbb_row_path #(.FRAC_BITS(FRAC_BITS)) u_path (
      .clk   (clk),
      .en    (en),
      .coefs (mat[r]),
      .bmin  (bmin),
      .bmax  (bmax),
      .lo    (lo[r]),
      .hi    (hi[r])
    );
  end

  // stage 5: extent, saturated to the size field, and output register
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      diff[a] = {hi[a][COORD_W-1], hi[a]} - {lo[a][COORD_W-1], lo[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        out_lo[a] <= lo[a];
        out_hi[a] <= hi[a];
        size_q[a] <= (diff[a][COORD_W] || diff[a][COORD_W-1]) ? {SIZE_W{1'b1}}
                                                              : diff[a][SIZE_W-1:0];
      end
    end
  end

  // output beat packing
  always_comb begin
    m_axis_tdata = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      m_axis_tdata[a*COORD_W +: COORD_W]           = out_lo[a];
      m_axis_tdata[(3+a)*COORD_W +: COORD_W]       = out_hi[a];
      m_axis_tdata[6*COORD_W + a*SIZE_W +: SIZE_W] = size_q[a];
    end
  end

  // a free output side lets every stage move, so the input must be open
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input closed while output side is free");

  // the transformed box is never inverted
  a_ordered: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(out_hi[0]) >= $signed(out_lo[0]) &&
                       $signed(out_hi[1]) >= $signed(out_lo[1]) &&
                       $signed(out_hi[2]) >= $signed(out_lo[2])))
    else $error("output box max below min");

  // a load beat of a valid row lands in the matrix
  a_row_load: assert property (@(posedge clk) disable iff (rst)
    (load && row < ROW_W'(NUM_ROWS)) |=> (mat[$past(row)] == $past(in_coefs)))
    else $error("matrix row not written by load beat");

endmodule

@@ tb/transformed_box_bounds_unit_tb.sv @@
// testbench of the transformed box bounds unit: bounds scoreboard, stream drivers, watchdog
`timescale 1ns / 100ps

module transformed_box_bounds_unit_tb;
  import tbb_pkg::*;

  localparam int FRAC = 16;
  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 6;
  localparam int IDLE_PCT = 14;
  localparam int RAND_ITEMS = 1900;
  localparam int CALM_FIRST = 700;
  localparam int CALM_LAST = 1000;
  localparam int DRAIN_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [ROW_W-1:0] ROW_UNUSED = 2'd3;

  // handy Q16.16 values
  localparam tbb_coord_t Q_ZERO = 32'h0000_0000;
  localparam tbb_coord_t Q_ONE = 32'h0001_0000;
  localparam tbb_coord_t Q_NEG_ONE = 32'hFFFF_0000;
  localparam tbb_coord_t Q_MAX = 32'h7FFF_FFFF;
  localparam tbb_coord_t Q_MIN = 32'h8000_0000;

  // one result beat, laid out exactly as m_axis_tdata without the pad
  typedef struct packed {
    logic [NUM_AXES-1:0][SIZE_W-1:0] extent;
    tbb_vec_t                        hi;
    tbb_vec_t                        lo;
  } bounds_t;

  // keeps its own copy of the matrix and the boxes still in flight
  class box_bounds_scoreboard;
    tbb_mat_t  mat;
    bounds_t   bounds_q[$];
    int        errors;
    string     axis_tag;

    function new();
      mat = '0;
      mat[0][0] = Q_ONE;
      mat[1][1] = Q_ONE;
      mat[2][2] = Q_ONE;
      errors = 0;
      axis_tag = "xyz";
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function longint widen(tbb_coord_t v);
      return longint'($signed(v));
    endfunction

    // one output row for one corner: floored products, exact sum, saturation
    function longint map_row(int r, longint x, longint y, longint z);
      longint s;
      longint top;
      top = (longint'(1) <<< (COORD_W - 1)) - 1;
      s = ((widen(mat[r][0]) * x) >>> FRAC) + ((widen(mat[r][1]) * y) >>> FRAC)
        + ((widen(mat[r][2]) * z) >>> FRAC) + widen(mat[r][3]);
      if (s > top) return top;
      if (s < -top - 1) return -top - 1;
      return s;
    endfunction

    // called for every accepted input beat
    function void note_input(logic act, logic [ROW_W-1:0] row, tbb_row_t coef,
                             tbb_vec_t bmin, tbb_vec_t bmax);
      bounds_t b;
      longint  lo [NUM_AXES];
      longint  hi [NUM_AXES];
      longint  x, y, z, t, d, size_top;
      int      k, a;
      if (act == ACT_LOAD) begin
        if (row < NUM_ROWS) mat[row] = coef;
        return;
      end
      size_top = (longint'(1) <<< SIZE_W) - 1;
      for (k = 0; k < 8; k++) begin
        x = widen((k & 1) ? bmax[0] : bmin[0]);
        y = widen((k & 2) ? bmax[1] : bmin[1]);
        z = widen((k & 4) ? bmax[2] : bmin[2]);
        for (a = 0; a < NUM_AXES; a++) begin
          t = map_row(a, x, y, z);
          if (k == 0 || t < lo[a]) lo[a] = t;
          if (k == 0 || t > hi[a]) hi[a] = t;
        end
      end
      for (a = 0; a < NUM_AXES; a++) begin
        d = hi[a] - lo[a];
        if (d > size_top) d = size_top;
        b.lo[a] = lo[a][COORD_W-1:0];
        b.hi[a] = hi[a][COORD_W-1:0];
        b.extent[a] = d[SIZE_W-1:0];
      end
      bounds_q = {bounds_q, b};
    endfunction

    // called for every accepted output beat
    task check_result(logic [OUT_TDATA_W-1:0] beat);
      bounds_t got, want;
      int      a;
      if (bounds_q.size() == 0) begin
        report($sformatf("result beat %h with no box pending", beat));
        return;
      end
      want = bounds_q.pop_front();
      got = beat[OUT_FIELDS_W-1:0];
      for (a = 0; a < NUM_AXES; a++) begin
        if (got.lo[a] !== want.lo[a])
          report($sformatf("out_min_%c got %h exp %h", axis_tag[a], got.lo[a], want.lo[a]));
        if (got.hi[a] !== want.hi[a])
          report($sformatf("out_max_%c got %h exp %h", axis_tag[a], got.hi[a], want.hi[a]));
        if (got.extent[a] !== want.extent[a])
          report($sformatf("size_%c got %h exp %h", axis_tag[a], got.extent[a],
                           want.extent[a]));
      end
    endtask

    function int pending();
      return bounds_q.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // coef_a, coef_b, coef_c, coef_d, min_x, min_y, min_z, max_x, max_y, max_z
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  // action, row
  logic [IN_TUSER_W-1:0]   s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // out_min_x..out_max_z, size_x, size_y, size_z, zero pad
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;

  box_bounds_scoreboard sb = new();
  bit  calm = 1'b0;
  int  quiet_cycles = 0;

  transformed_box_bounds_unit #(
    .FRAC_BITS(FRAC)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // random backpressure on the result side
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // result beats are taken between edges, while everything is settled
  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // watchdog: ends the run after too many cycles without any beat
  always @(negedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function tbb_row_t make_row(tbb_coord_t a, tbb_coord_t b, tbb_coord_t c, tbb_coord_t d);
    tbb_row_t r;
    r[0] = a;
    r[1] = b;
    r[2] = c;
    r[3] = d;
    return r;
  endfunction

  function tbb_vec_t make_vec(tbb_coord_t x, tbb_coord_t y, tbb_coord_t z);
    tbb_vec_t v;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    return v;
  endfunction

  function tbb_coord_t edge_value();
    case ($urandom_range(0, 6))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return Q_ZERO;
      3: return 32'hFFFF_FFFF;
      4: return Q_ONE;
      5: return Q_NEG_ONE;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // coordinates: half within +-16.0, some full range, some corner values, some whole numbers within +-100
  function tbb_coord_t rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return tbb_coord_t'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
    if (pick < 8) return $urandom;
    if (pick < 9) return edge_value();
    return tbb_coord_t'($urandom_range(0, 200) - 100) << FRAC;
  endfunction

  // coefficients: mostly within +-4.0, some full range, some corner values, some whole numbers within +-4
  function tbb_coord_t rand_coef();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return tbb_coord_t'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
    if (pick < 8) return $urandom;
    if (pick < 9) return edge_value();
    return tbb_coord_t'($urandom_range(0, 8) - 4) << FRAC;
  endfunction

  // drives one input beat; entered and left on a rising edge
  task send_beat(logic act, logic [ROW_W-1:0] row, tbb_row_t coef,
                 tbb_vec_t bmin, tbb_vec_t bmax);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= {row, act};
    s_axis_tdata <= {bmax, bmin, coef};
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    sb.note_input(act, row, coef, bmin, bmax);
    @(posedge clk);
  endtask

  // matrix row load, box fields filled with noise
  task load_row(logic [ROW_W-1:0] r, tbb_row_t coef);
    send_beat(ACT_LOAD, r, coef, make_vec($urandom, $urandom, $urandom),
              make_vec($urandom, $urandom, $urandom));
  endtask

  // box beat, coefficient and row fields filled with noise
  task send_box(tbb_vec_t bmin, tbb_vec_t bmax);
    send_beat(ACT_BOX, ROW_W'($urandom_range(0, 3)),
              make_row($urandom, $urandom, $urandom, $urandom), bmin, bmax);
  endtask

  initial begin
    int         counted;
    int         pick;
    int         a;
    tbb_vec_t   bmin, bmax;
    tbb_coord_t swap_tmp;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // identity matrix after reset: plain, full-range, inverted and point boxes
    send_box(make_vec(Q_ZERO, Q_ZERO, Q_ZERO), make_vec(Q_ONE, 32'h0002_0000, 32'h0003_0000));
    send_box(make_vec(Q_MIN, Q_MIN, Q_MIN), make_vec(Q_MAX, Q_MAX, Q_MAX));
    send_box(make_vec(32'h0005_0000, Q_ONE, 32'h0000_8000),
             make_vec(32'hFFFB_0000, Q_NEG_ONE, 32'hFFFF_8000));
    send_box(make_vec(32'hFFFE_1234, 32'h0000_0007, Q_MIN),
             make_vec(32'hFFFE_1234, 32'h0000_0007, Q_MIN));

    // load of the unused row index leaves the identity in place
    load_row(ROW_UNUSED, make_row(Q_MAX, Q_MIN, 32'h1234_5678, 32'hDEAD_BEEF));
    send_box(make_vec(Q_NEG_ONE, 32'h0000_0003, Q_MAX), make_vec(Q_ONE, 32'h0004_0000, Q_MAX));

    // extreme coefficients drive the row sums into both saturation limits
    load_row(2'd0, make_row(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    load_row(2'd1, make_row(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    load_row(2'd2, make_row(32'hFFFF_8000, 32'h0000_4000, Q_NEG_ONE, 32'hFFFF_FFFF));
    send_box(make_vec(Q_MIN, Q_MIN, Q_MIN), make_vec(Q_MAX, Q_MAX, Q_MAX));
    send_box(make_vec(Q_ONE, Q_ONE, Q_ONE), make_vec(Q_MAX, Q_MAX, Q_MAX));

    // tiny odd coordinates show the floor of negative products
    send_box(make_vec(32'hFFFF_FFFD, 32'h0000_0001, 32'h0000_0007),
             make_vec(32'h0000_0003, 32'h0000_0005, 32'h0001_2345));

    // axis swap with scale and translation
    load_row(2'd0, make_row(Q_ZERO, Q_ONE, Q_ZERO, 32'h000A_0000));
    load_row(2'd1, make_row(Q_NEG_ONE, Q_ZERO, Q_ZERO, 32'hFFFD_8000));
    load_row(2'd2, make_row(Q_ZERO, Q_ZERO, 32'h0002_0000, Q_ZERO));
    send_box(make_vec(32'hFFFF_0001, 32'h0001_8000, 32'hFFFC_0000),
             make_vec(32'h0003_4000, 32'h0007_0000, 32'h0000_0011));

    // back to identity
    load_row(2'd0, make_row(Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO));
    load_row(2'd1, make_row(Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO));
    load_row(2'd2, make_row(Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO));
    send_box(make_vec(Q_ZERO, Q_ZERO, Q_ZERO), make_vec(Q_ZERO, Q_ZERO, Q_ZERO));

    // random traffic: mostly boxes, some row loads, a few ignored loads
    counted = 0;
    while (counted < RAND_ITEMS) begin
      calm = (counted >= CALM_FIRST && counted < CALM_LAST);
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        for (a = 0; a < NUM_AXES; a++) begin
          bmin[a] = rand_coord();
          bmax[a] = rand_coord();
          // keep most boxes well ordered, leave some inverted
          if ($urandom_range(0, 9) != 0 && $signed(bmin[a]) > $signed(bmax[a])) begin
            swap_tmp = bmin[a];
            bmin[a] = bmax[a];
            bmax[a] = swap_tmp;
          end
        end
        send_box(bmin, bmax);
        counted++;
      end else if (pick < 97) begin
        load_row(ROW_W'($urandom_range(0, NUM_ROWS - 1)),
                 make_row(rand_coef(), rand_coef(), rand_coef(), rand_coord()));
        counted++;
      end else begin
        load_row(ROW_UNUSED, make_row($urandom, $urandom, $urandom, $urandom));
      end
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    // drain, then let the pipeline settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tbb_pkg.sv
rtl/tbb_matrix.sv
rtl/tbb_pipe_ctl.sv
rtl/tbb_row_path.sv
rtl/transformed_box_bounds_unit.sv
tb/transformed_box_bounds_unit_tb.sv
